[hw/rtl/vsc_pkg.sv]
package vsc_pkg;

   // Number of key letters held in the key register.
   localparam int MAX_KEY_LETTERS = 12;
   localparam int KEY_SHIFT_W     = 5;
   localparam int KEY_LETTERS_W   = MAX_KEY_LETTERS * KEY_SHIFT_W;
   localparam int KEY_POS_W       = 4;

   localparam logic [7:0] UPPER_A    = 8'd65;
   localparam logic [7:0] UPPER_Z    = 8'd90;
   localparam logic [7:0] LOWER_A    = 8'd97;
   localparam logic [7:0] LOWER_Z    = 8'd122;
   localparam logic [7:0] SPACE_BYTE = 8'd32;
   localparam logic [6:0] OUT_A      = 7'd65;
   localparam logic [6:0] OUT_SPACE  = 7'd32;
   localparam logic [5:0] ALPHA_SIZE = 6'd26;

   // Queue between the classifier and the cipher stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Register indexes, taken from paddr[4:3].
   localparam logic [1:0] REG_KEY_LETTERS  = 2'd0;
   localparam logic [1:0] REG_KEY_LENGTH   = 2'd1;
   localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

   typedef struct packed {
      logic [KEY_LETTERS_W-1:0] key_letters;
      logic [KEY_POS_W-1:0]     key_length;
   } key_cfg_type;

   // One classified word waiting for the cipher stage.
   typedef struct packed {
      logic                   is_space;
      logic [4:0]             letter;
      logic [KEY_SHIFT_W-1:0] shift;
   } queue_entry_type;

endpackage

[hw/rtl/vigenere_stream_cipher_unit.sv]
// Vigenere stream cipher. Each message byte arrives as one word on the req_ stream, with
// req_tuser marking the start of a message (the key position returns to zero before that
// byte). ASCII letters are uppercased and shifted through A..Z by the current key letter,
// forward when encrypting and backward when decrypting; a space comes out unchanged and
// leaves the key position alone; every other byte is swallowed and gives no word on the
// rsp_ stream. The block sustains one byte per clock cycle while the queue is not full. A
// byte is classified and its key shift selected in the cycle it is accepted, it waits in
// a four-entry queue, and the cipher stage writes the result into the output register.
// The front end stalls only when the queue is full, and the output register can be
// refilled in the same cycle that its word is taken. The key (twelve 5-bit shifts), key
// length and direction sit on an APB-style register port at byte addresses 0, 8 and 16;
// they should be changed only while no bytes are in flight.
module vigenere_stream_cipher_unit
   import vsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input stream: tdata bits 7:0 in_byte; tuser bit 0 message_start.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   // Output stream: tdata bits 6:0 out_char, bit 7 zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [KEY_LETTERS_W-1:0] key_letters_ff;
   logic [KEY_POS_W-1:0]     key_length_ff;
   logic                     decrypt_mode_ff;
   logic                     csr_write;
   logic [1:0]               reg_index;
   key_cfg_type              key_cfg;
   queue_entry_type          push_entry;
   queue_entry_type          pop_entry;
   logic                     push_valid;
   logic                     push_ready;
   logic                     pop_valid;
   logic                     pop_ready;

   // Registers are eight bytes apart, so the index is the address without its low bits.
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:3];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_letters_ff  <= '0;
         key_length_ff   <= KEY_POS_W'(1);
         decrypt_mode_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_KEY_LETTERS:  key_letters_ff  <= csr_pwdata[KEY_LETTERS_W-1:0];
            REG_KEY_LENGTH:   key_length_ff   <= csr_pwdata[KEY_POS_W-1:0];
            REG_DECRYPT_MODE: decrypt_mode_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_KEY_LETTERS:  csr_prdata = {{(64-KEY_LETTERS_W){1'b0}}, key_letters_ff};
         REG_KEY_LENGTH:   csr_prdata = {{(64-KEY_POS_W){1'b0}}, key_length_ff};
         REG_DECRYPT_MODE: csr_prdata = {63'd0, decrypt_mode_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign key_cfg.key_letters = key_letters_ff;
   assign key_cfg.key_length  = key_length_ff;

   // The front end holds the key position and picks the shift for each letter.
   vsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .key_cfg    (key_cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   vsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // The back end does the wrapped add or subtract and owns the output register.
   vsc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .decrypt_mode (decrypt_mode_ff),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_entry    (pop_entry),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

[hw/rtl/vsc_front.sv]
module vsc_front
   import vsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  key_cfg_type     key_cfg,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,
   input  logic            req_tuser,
   output logic            push_valid,
   input  logic            push_ready,
   output queue_entry_type push_entry
);

   logic [KEY_POS_W-1:0]   key_pos_ff;
   logic [KEY_POS_W-1:0]   key_pos_in;
   logic [KEY_POS_W-1:0]   pos_cur;
   logic [KEY_POS_W-1:0]   pos_inc;
   logic [KEY_POS_W-1:0]   eff_len;
   logic [KEY_SHIFT_W-1:0] raw_shift;
   logic [7:0]             letter_off;
   logic                   is_upper;
   logic                   is_lower;
   logic                   is_space;
   logic                   is_letter;
   logic                   accept;

   assign req_tready = push_ready;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      is_upper   = (req_tdata >= UPPER_A) && (req_tdata <= UPPER_Z);
      is_lower   = (req_tdata >= LOWER_A) && (req_tdata <= LOWER_Z);
      is_space   = (req_tdata == SPACE_BYTE);
      is_letter  = is_upper | is_lower;
      letter_off = req_tdata - (is_upper ? UPPER_A : LOWER_A);

      pos_cur = req_tuser ? '0 : key_pos_ff;

      raw_shift = '0;
      for (int i = 0; i < MAX_KEY_LETTERS; i++) begin
         if (pos_cur == i[KEY_POS_W-1:0]) begin
            raw_shift = key_cfg.key_letters[KEY_SHIFT_W*i +: KEY_SHIFT_W];
         end
      end

      push_entry.is_space = is_space;
      push_entry.letter   = letter_off[4:0];
      push_entry.shift    = (raw_shift >= ALPHA_SIZE[KEY_SHIFT_W-1:0]) ?
                            raw_shift - ALPHA_SIZE[KEY_SHIFT_W-1:0] : raw_shift;
      push_valid          = accept & (is_space | is_letter);

      // A length of zero behaves as one, and anything above the key size saturates.
      if (key_cfg.key_length == '0) begin
         eff_len = KEY_POS_W'(1);
      end else if (key_cfg.key_length > KEY_POS_W'(MAX_KEY_LETTERS)) begin
         eff_len = KEY_POS_W'(MAX_KEY_LETTERS);
      end else begin
         eff_len = key_cfg.key_length;
      end

      pos_inc = pos_cur + KEY_POS_W'(1);

      key_pos_in = key_pos_ff;
      if (accept) begin
         if (is_letter) begin
            key_pos_in = (pos_inc >= eff_len) ? '0 : pos_inc;
         end else begin
            key_pos_in = pos_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_pos_ff <= '0;
      end else begin
         key_pos_ff <= key_pos_in;
      end
   end

endmodule

[hw/rtl/vsc_queue.sv]
module vsc_queue
   import vsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  queue_entry_type push_entry,
   output logic            pop_valid,
   input  logic            pop_ready,
   output queue_entry_type pop_entry
);

   queue_entry_type        slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[hw/rtl/vsc_back.sv]
module vsc_back
   import vsc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            decrypt_mode,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  queue_entry_type pop_entry,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata
);

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [6:0] rsp_char_ff;
   logic [6:0] rsp_char_in;
   logic [5:0] sum;
   logic [5:0] diff;
   logic [5:0] wrapped;
   logic       take;

   assign pop_ready  = !rsp_valid_ff || rsp_tready;
   assign take       = pop_valid & pop_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_char_ff};

   always_comb begin
      sum  = {1'b0, pop_entry.letter} + {1'b0, pop_entry.shift};
      diff = {1'b0, pop_entry.letter} - {1'b0, pop_entry.shift};
      if (decrypt_mode) begin
         // Bit 5 set means the difference went below zero.
         wrapped = diff[5] ? diff + ALPHA_SIZE : diff;
      end else begin
         wrapped = (sum >= ALPHA_SIZE) ? sum - ALPHA_SIZE : sum;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = pop_entry.is_space ? OUT_SPACE : OUT_A + {2'b00, wrapped[4:0]};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
   import vsc_pkg::*;

   // Cycles allowed after the last expected word before the block counts as idle. A
   // byte that gives no word never enters the four-entry queue or the output register, so
   // once the last expected word is out the pipe is already empty and this is margin.
   localparam int DRAIN_CYCLES     = 12;
   // Words checked before the receiver starts its one long hold-off.
   localparam int HOLD_AFTER       = 500;
   localparam int LONG_HOLD_CYCLES = 300;
   // Input words sent, directed part included.
   localparam int ITEM_TARGET      = 1650;

   // Keeps its own copy of the key registers and of the key position, works out the
   // character expected for every accepted byte and checks the words that come back
   // in order.
   class vigenere_scoreboard;
      logic [KEY_LETTERS_W-1:0] key_shifts;
      logic [KEY_POS_W-1:0]     key_len;
      logic                     decrypt;
      logic [KEY_POS_W-1:0]     key_pos;
      logic [6:0]               expected_chars[$];
      int unsigned errors, letters, spaces, dropped, expected_total, checked, accepted;

      function new();
         key_shifts     = '0;
         key_len        = 4'd1;
         decrypt        = 1'b0;
         key_pos        = '0;
         errors         = 0;
         letters        = 0;
         spaces         = 0;
         dropped        = 0;
         expected_total = 0;
         checked        = 0;
         accepted       = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [63:0] value);
         case (index)
            REG_KEY_LETTERS:  key_shifts = value[KEY_LETTERS_W-1:0];
            REG_KEY_LENGTH:   key_len = value[KEY_POS_W-1:0];
            REG_DECRYPT_MODE: decrypt = value[0];
            default: ;
         endcase
      endfunction

      function void note_byte(logic [7:0] in_byte, logic message_start);
         int letter;
         int shift;
         int span;
         int slot;
         accepted++;
         if (message_start)
            key_pos = '0;
         if (in_byte == SPACE_BYTE) begin
            expected_chars.push_back(OUT_SPACE);
            spaces++;
            expected_total++;
            return;
         end
         if (in_byte >= UPPER_A && in_byte <= UPPER_Z)
            letter = int'(in_byte - UPPER_A);
         else if (in_byte >= LOWER_A && in_byte <= LOWER_Z)
            letter = int'(in_byte - LOWER_A);
         else begin
            dropped++;
            return;
         end
         // Shift codes 26..31 fold back into the alphabet.
         slot  = int'(key_pos) % MAX_KEY_LETTERS;
         shift = int'(key_shifts[KEY_SHIFT_W*slot +: KEY_SHIFT_W]) % int'(ALPHA_SIZE);
         if (decrypt)
            letter = (letter + int'(ALPHA_SIZE) - shift) % int'(ALPHA_SIZE);
         else
            letter = (letter + shift) % int'(ALPHA_SIZE);
         expected_chars.push_back(OUT_A + 7'(letter));
         letters++;
         expected_total++;
         // A length of zero acts as one, anything past the key store saturates.
         if (key_len == 0)
            span = 1;
         else if (int'(key_len) > MAX_KEY_LETTERS)
            span = MAX_KEY_LETTERS;
         else
            span = int'(key_len);
         if (int'(key_pos) + 1 >= span)
            key_pos = '0;
         else
            key_pos = key_pos + 1'b1;
      endfunction

      function void check_char(logic [7:0] tdata);
         logic [6:0] want;
         checked++;
         if (expected_chars.size() == 0) begin
            errors++;
            $error("out_char: expected nothing, actual %0d", tdata[6:0]);
            return;
         end
         want = expected_chars.pop_front();
         if (tdata[6:0] !== want) begin
            errors++;
            $error("out_char: expected %0d, actual %0d", want, tdata[6:0]);
         end
         if (tdata[7] !== 1'b0) begin
            errors++;
            $error("rsp_tdata padding: expected 0, actual %b", tdata[7]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // bits 7:0 in_byte
   logic        req_tuser;   // bit 0 message_start
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // bits 6:0 out_char, bit 7 zero
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   vigenere_scoreboard board = new();
   int unsigned register_writes = 0;
   int unsigned phases = 0;
   int unsigned longest_hold = 0;

   vigenere_stream_cipher_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 4 ns period; the first rising edge falls at 2 ns.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Both monitors sample at the rising edge, where the testbench process wakes before
   // any of the block's registers update, so they see the values that the block saw.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_byte(req_tdata, req_tuser);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_char(rsp_tdata);
   end

   // Safety net: far beyond the slowest correct run, including the long hold-off.
   initial begin
      #2_000_000;
      $display("vigenere_stream_cipher_unit regression: fail");
      $finish;
   end

   // Receiver. After each randomly long stretch it picks again between always ready, a coin
   // toss, mostly stalled and a fixed one-in-three stall pattern. Once enough words have
   // come through, and while the sender is offering, it holds off for a long stretch so
   // that the queue fills and the block pushes back on the sender.
   initial begin : receiver
      int  mode;
      int  span;
      int  phase_count;
      bit  held;
      rsp_tready = 1'b0;
      phase_count = 0;
      held = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(8, 64);
         repeat (span) begin
            @(negedge clock);
            if (!held && board.checked >= HOLD_AFTER && req_tvalid) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD_CYCLES) @(negedge clock);
               longest_hold = LONG_HOLD_CYCLES;
               held = 1'b1;
            end
            phase_count++;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (phase_count % 3 != 0);
            endcase
         end
      end
   end

   // Offers one byte and holds it until the block takes it.
   task automatic send_word(input logic [7:0] in_byte, input logic message_start);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= in_byte;
      req_tuser  <= message_start;
      do @(posedge clock); while (!req_tready);
   endtask

   // Leaves the input idle for the given number of cycles, with rubbish on the data lines.
   task automatic idle_sender(input int unsigned cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tdata  <= 8'($urandom);
      req_tuser  <= 1'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Closes a phase: stops offering, waits for every expected word and then lets the
   // pipe run dry so that a register write cannot overtake a byte still in flight.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      phases++;
   endtask

   // Register write in a setup and an access phase; the value lands at the access edge.
   task automatic write_register(input logic [1:0] index, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_register(index, value);
      register_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly letters of either case, a fair share of spaces, and the rest any byte at all
   // so that punctuation, control codes and the top half of the byte range turn up.
   function automatic logic [7:0] message_byte();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         return UPPER_A + 8'($urandom_range(0, 25));
      if (pick < 70)
         return LOWER_A + 8'($urandom_range(0, 25));
      if (pick < 82)
         return SPACE_BYTE;
      return 8'($urandom);
   endfunction

   // New settings for a phase. Each register is rewritten two times in three, so the
   // key position often carries over a change of key or length.
   task automatic random_settings();
      logic [63:0] key;
      logic [3:0]  length;
      int          i;
      if ($urandom_range(0, 2) != 0) begin
         key = {$urandom, $urandom};
         case ($urandom_range(0, 5))
            0: key = '0;
            1: key = '1;
            2: for (i = 0; i < MAX_KEY_LETTERS; i++)
                  key[KEY_SHIFT_W*i +: KEY_SHIFT_W] = 5'd25;
            3: for (i = 0; i < MAX_KEY_LETTERS; i++)
                  case ($urandom_range(0, 3))
                     0: key[KEY_SHIFT_W*i +: KEY_SHIFT_W] = 5'd0;
                     1: key[KEY_SHIFT_W*i +: KEY_SHIFT_W] = 5'd25;
                     2: key[KEY_SHIFT_W*i +: KEY_SHIFT_W] = 5'd26;
                     default: key[KEY_SHIFT_W*i +: KEY_SHIFT_W] = 5'd31;
                  endcase
            default: ;
         endcase
         write_register(REG_KEY_LETTERS, key);
      end
      if ($urandom_range(0, 2) != 0) begin
         case ($urandom_range(0, 9))
            0: length = 4'd0;
            1: length = 4'd1;
            2: length = 4'd12;
            3: length = 4'($urandom_range(13, 15));
            default: length = 4'($urandom_range(1, 12));
         endcase
         write_register(REG_KEY_LENGTH, {60'd0, length});
      end
      if ($urandom_range(0, 2) != 0)
         write_register(REG_DECRYPT_MODE, {63'd0, 1'($urandom_range(0, 1))});
   endtask

   // A phase of messages: each one normally opens with the start flag, but now and then
   // the flag is missing or turns up in the middle. The sender works in bursts with
   // random gaps, except in some phases where it never lets go of valid.
   task automatic random_phase(input int unsigned words);
      int unsigned base;
      int unsigned burst;
      int unsigned msg_left;
      bit          gapless;
      logic        start;
      base     = board.accepted;
      gapless  = ($urandom_range(0, 4) == 0);
      burst    = $urandom_range(1, 24);
      msg_left = 0;
      while (board.accepted - base < words) begin
         start = 1'b0;
         if (msg_left == 0) begin
            msg_left = $urandom_range(1, 40);
            start = ($urandom_range(0, 7) != 0);
         end else if ($urandom_range(0, 49) == 0) begin
            start = 1'b1;
         end
         msg_left--;
         send_word(message_byte(), start);
         if (!gapless) begin
            if (burst == 0) begin
               idle_sender($urandom_range(1, 8));
               burst = $urandom_range(1, 24);
            end else begin
               burst--;
            end
         end
      end
      settle();
   endtask

   initial begin : stimulus
      logic [63:0] key;
      int          i;
      int unsigned words;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'd0;
      req_tuser   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Settings straight out of reset: zero key, one letter, encrypting. The lowest upper-case
      // and the highest lower-case letter, a space, and the bytes just outside every letter range
      // along with the extremes of the byte, all of which must vanish.
      send_word(8'h41, 1'b1);
      send_word(8'h7a, 1'b0);
      send_word(SPACE_BYTE, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'hff, 1'b1);
      send_word(8'h40, 1'b0);
      send_word(8'h5b, 1'b0);
      send_word(8'h60, 1'b0);
      send_word(8'h7b, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h7f, 1'b0);
      settle();

      // Shift codes 25, 26 and 31 in the first three slots, so the wrap past Z and the
      // folding of codes above 25 both show; a space in the middle must not use up a
      // key letter, and the start flag on the last byte rewinds the key.
      key = {$urandom, $urandom};
      key[4:0]   = 5'd25;
      key[9:5]   = 5'd26;
      key[14:10] = 5'd31;
      key[19:15] = 5'd0;
      write_register(REG_KEY_LETTERS, key);
      write_register(REG_KEY_LENGTH, 64'd4);
      send_word(8'h5a, 1'b1);
      send_word(8'h61, 1'b0);
      send_word(SPACE_BYTE, 1'b0);
      send_word(8'h7a, 1'b0);
      send_word(8'h6d, 1'b0);
      send_word(8'h42, 1'b1);
      settle();

      // Decrypting with a key length of zero, which behaves as one.
      write_register(REG_DECRYPT_MODE, 64'd1);
      write_register(REG_KEY_LENGTH, 64'd0);
      send_word(8'h41, 1'b1);
      send_word(8'h61, 1'b0);
      send_word(8'h5a, 1'b0);
      settle();

      // A length of fifteen saturates at twelve: the thirteenth and fourteenth letters
      // come round to the first key letters again. The key is all ones in the spare top
      // bits to check that they are ignored.
      key = {$urandom, $urandom};
      key[63:60] = 4'hf;
      write_register(REG_KEY_LETTERS, key);
      write_register(REG_KEY_LENGTH, 64'd15);
      write_register(REG_DECRYPT_MODE, 64'd0);
      for (i = 0; i < 14; i++)
         send_word(UPPER_A + 8'(i), i == 0);
      settle();

      // The key position now sits at two; shrinking the key to two letters means the
      // next letter still uses slot two and the one after wraps to slot zero.
      write_register(REG_KEY_LENGTH, 64'd2);
      send_word(8'h51, 1'b0);
      send_word(8'h71, 1'b0);
      settle();

      // Random phases until the bulk of the words has gone through, the settings
      // changing between phases and the key position carrying over.
      while (board.accepted < ITEM_TARGET) begin
         random_settings();
         words = $urandom_range(20, 150);
         if (words > ITEM_TARGET - board.accepted)
            words = ITEM_TARGET - board.accepted;
         random_phase(words);
      end

      $display("Covered %0d letters, %0d spaces and %0d dropped bytes in %0d phases",
               board.letters, board.spaces, board.dropped, phases);
      $display("with %0d register writes and a %0d-cycle receiver hold-off; %0d mismatches.",
               register_writes, longest_hold, board.errors);
      if (board.errors == 0)
         $display("vigenere_stream_cipher_unit regression: pass");
      else
         $display("vigenere_stream_cipher_unit regression: fail");
      $finish;
   end

endmodule

[vigenere_stream_cipher_unit.f]
hw/rtl/vsc_pkg.sv
hw/rtl/vsc_front.sv
hw/rtl/vsc_queue.sv
hw/rtl/vsc_back.sv
hw/rtl/vigenere_stream_cipher_unit.sv
bench/tb.sv
